// ----- src/sita_pkg.sv -----
`timescale 1ns / 1ps

package sita_pkg;

   // Default configuration of the converter.
   localparam int VALUE_BITS_DEF = 32;
   localparam int MAX_RADIX_DEF  = 16;

   // Fixed field widths.
   localparam int RADIX_W  = 6;
   localparam int CHAR_W   = 8;
   localparam int COUNT_W  = 6;
   localparam int INPUT_W  = 32;
   localparam int STEP_W   = 8;

   // Radix register reset value and lower limit.
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] MIN_RADIX   = 6'd2;

   // Character codes.
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] LETTER_GAP  = 8'd7;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_SIGN,
      BK_EMIT,
      BK_ERR
   } back_state_type;

   // Classification of one item, handed from the front to the back.
   typedef struct packed {
      logic                neg;
      logic                err;
      logic [RADIX_W-1:0]  base;
   } item_tag_type;

   // Result of one eight-bit long-division step.
   typedef struct packed {
      logic [STEP_W-1:0]   quot;
      logic [RADIX_W-1:0]  rem;
   } div_step_type;

   // Eight restoring-division steps of a byte against a small divisor.
   // The incoming remainder is always below the divisor.
   function automatic div_step_type div_step(input logic [RADIX_W-1:0] rem_i,
                                             input logic [STEP_W-1:0]  bits_i,
                                             input logic [RADIX_W-1:0] base_i);
      div_step_type      res;
      logic [RADIX_W:0]  part;
      int                k;
      part = {1'b0, rem_i};
      res.quot = '0;
      for (k = STEP_W - 1; k >= 0; k--) begin
         part = {part[RADIX_W-1:0], bits_i[k]};
         if (part >= {1'b0, base_i}) begin
            part        = part - {1'b0, base_i};
            res.quot[k] = 1'b1;
         end
      end
      res.rem = part[RADIX_W-1:0];
      return res;
   endfunction

   // Digit value to its character: '0'..'9', then 'A' upward.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] c;
      c = ASCII_ZERO + {2'b00, d};
      if (d > 6'd9) begin
         c = c + LETTER_GAP;
      end
      return c;
   endfunction

endpackage

// ----- src/sita_front.sv -----
`timescale 1ns / 1ps

module sita_front #(
   parameter int VALUE_BITS = sita_pkg::VALUE_BITS_DEF,
   parameter int MAX_RADIX  = sita_pkg::MAX_RADIX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [sita_pkg::INPUT_W-1:0] req_value,
   input  logic [sita_pkg::RADIX_W-1:0]  radix,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [VALUE_BITS-1:0]         out_mag,
   output sita_pkg::item_tag_type        out_tag
);

   logic                    valid_ff, valid_in;
   logic [VALUE_BITS-1:0]   mag_ff, mag_in;
   sita_pkg::item_tag_type  tag_ff, tag_in;
   logic [VALUE_BITS-1:0]   raw_c;
   logic                    neg_c;
   logic                    accept;

   // Take the low VALUE_BITS bits, sign-extending a narrow input word.
   generate
      if (VALUE_BITS <= sita_pkg::INPUT_W) begin : g_narrow
         assign raw_c = req_value[VALUE_BITS-1:0];
      end else begin : g_wide
         assign raw_c = {{(VALUE_BITS - sita_pkg::INPUT_W){req_value[sita_pkg::INPUT_W-1]}},
                         req_value};
      end
   endgenerate

   assign neg_c     = raw_c[VALUE_BITS-1];
   assign req_ready = !valid_ff || out_ready;
   assign accept    = req_valid && req_ready;

   // Classify the transaction: sign, magnitude and radix check.
   always_comb begin
      mag_in   = mag_ff;
      tag_in   = tag_ff;
      valid_in = valid_ff && !out_ready;
      if (accept) begin
         valid_in    = 1'b1;
         mag_in      = neg_c ? (~raw_c + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw_c;
         tag_in.neg  = neg_c;
         tag_in.base = radix;
         tag_in.err  = (radix < sita_pkg::MIN_RADIX) ||
                       (radix > sita_pkg::RADIX_W'(MAX_RADIX));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      mag_ff <= mag_in;
      tag_ff <= tag_in;
   end

   assign out_valid = valid_ff;
   assign out_mag   = mag_ff;
   assign out_tag   = tag_ff;

endmodule

// ----- src/sita_queue.sv -----
`timescale 1ns / 1ps

module sita_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   // Two-entry queue between the front and the back.
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/sita_back.sv -----
`timescale 1ns / 1ps

module sita_back #(
   parameter int VALUE_BITS = sita_pkg::VALUE_BITS_DEF,
   parameter int MAX_RADIX  = sita_pkg::MAX_RADIX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [VALUE_BITS-1:0]         in_mag,
   input  sita_pkg::item_tag_type        in_tag,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sita_pkg::CHAR_W-1:0]   rsp_ascii_char,
   output logic                          rsp_last_char,
   output logic [sita_pkg::COUNT_W-1:0]  rsp_char_count,
   output logic                          rsp_radix_error
);

   localparam int CHUNKS = (VALUE_BITS + sita_pkg::STEP_W - 1) / sita_pkg::STEP_W;
   localparam int PADW   = CHUNKS * sita_pkg::STEP_W;
   localparam int CKW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int AW     = $clog2(VALUE_BITS);
   localparam int CW     = $clog2(VALUE_BITS + 1);
   localparam int RW     = sita_pkg::RADIX_W;

   sita_pkg::back_state_type  state_ff, state_in;
   sita_pkg::item_tag_type    tag_ff, tag_in;
   logic [PADW-1:0]           mag_ff, mag_in;
   logic [RW-1:0]             rem_ff, rem_in;
   logic [CKW-1:0]            chunk_ff, chunk_in;
   logic                      nz_ff, nz_in;
   logic [CW-1:0]             n_ff, n_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             left_ff, left_in;
   logic [CW:0]               total_ff, total_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sita_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [sita_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                         rsp_err_ff, rsp_err_in;

   // Digit store, written least significant digit first.
   logic [RW-1:0]  digit_mem [VALUE_BITS];
   logic [RW-1:0]  rd_data_ff;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [RW-1:0]  wr_data;

   sita_pkg::div_step_type  step;
   logic                    slot_free;
   logic                    chunk_last;
   logic                    quot_nz;
   logic [CW-1:0]           n_next;
   logic                    div_done;
   logic                    emit_fire;
   logic                    emit_last;

   // Shared divide datapath: one byte of the magnitude per cycle.
   assign step       = sita_pkg::div_step(rem_ff, mag_ff[PADW-1 -: sita_pkg::STEP_W],
                                          tag_ff.base);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign chunk_last = (chunk_ff == CKW'(CHUNKS - 1));
   assign quot_nz    = nz_ff || (step.quot != '0);
   assign n_next     = n_ff + {{(CW-1){1'b0}}, 1'b1};
   assign div_done   = chunk_last && (!quot_nz || (n_next == CW'(VALUE_BITS)));
   assign emit_last  = (left_ff == {{(CW-1){1'b0}}, 1'b1});
   assign emit_fire  = (state_ff == sita_pkg::BK_EMIT) && slot_free;
   assign rd_addr    = (emit_fire && (idx_ff != '0)) ? (idx_ff - {{(AW-1){1'b0}}, 1'b1})
                                                      : idx_ff;
   assign in_ready   = (state_ff == sita_pkg::BK_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sita_pkg::BK_IDLE: begin
            if (in_valid) begin
               state_in = in_tag.err ? sita_pkg::BK_ERR : sita_pkg::BK_DIV;
            end
         end
         sita_pkg::BK_DIV: begin
            if (div_done) begin
               state_in = sita_pkg::BK_SIGN;
            end
         end
         sita_pkg::BK_SIGN: begin
            if (!tag_ff.neg || slot_free) begin
               state_in = sita_pkg::BK_EMIT;
            end
         end
         sita_pkg::BK_EMIT: begin
            if (slot_free && emit_last) begin
               state_in = sita_pkg::BK_IDLE;
            end
         end
         sita_pkg::BK_ERR: begin
            if (slot_free) begin
               state_in = sita_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = sita_pkg::BK_IDLE;
         end
      endcase
   end

   // Datapath and result register updates.
   always_comb begin
      tag_in       = tag_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      chunk_in     = chunk_ff;
      nz_in        = nz_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      total_in     = total_ff;
      wr_en        = 1'b0;
      wr_addr      = n_ff[AW-1:0];
      wr_data      = step.rem;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         sita_pkg::BK_IDLE: begin
            if (in_valid) begin
               tag_in   = in_tag;
               mag_in   = PADW'(in_mag);
               rem_in   = '0;
               chunk_in = '0;
               nz_in    = 1'b0;
               n_in     = '0;
            end
         end
         sita_pkg::BK_DIV: begin
            mag_in   = (mag_ff << sita_pkg::STEP_W) | PADW'(step.quot);
            rem_in   = step.rem;
            nz_in    = quot_nz;
            chunk_in = chunk_ff + {{(CKW-1){1'b0}}, 1'b1};
            if (chunk_last) begin
               // One digit finished: store it and restart on the quotient.
               wr_en    = 1'b1;
               rem_in   = '0;
               chunk_in = '0;
               nz_in    = 1'b0;
               n_in     = n_next;
               if (div_done) begin
                  idx_in   = n_ff[AW-1:0];
                  left_in  = n_next;
                  total_in = {1'b0, n_next} + {{CW{1'b0}}, tag_ff.neg};
               end
            end
         end
         sita_pkg::BK_SIGN: begin
            if (tag_ff.neg && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = sita_pkg::ASCII_MINUS;
               rsp_last_in  = 1'b0;
               rsp_count_in = '0;
               rsp_err_in   = 1'b0;
            end
         end
         sita_pkg::BK_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = sita_pkg::digit_char(rd_data_ff);
               rsp_last_in  = emit_last;
               rsp_count_in = emit_last ? sita_pkg::COUNT_W'(total_ff) : '0;
               rsp_err_in   = 1'b0;
               left_in      = left_ff - {{(CW-1){1'b0}}, 1'b1};
               idx_in       = rd_addr;
            end
         end
         sita_pkg::BK_ERR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = sita_pkg::ASCII_NUL;
               rsp_last_in  = 1'b1;
               rsp_count_in = '0;
               rsp_err_in   = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sita_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tag_ff       <= tag_in;
      mag_ff       <= mag_in;
      rem_ff       <= rem_in;
      chunk_ff     <= chunk_in;
      nz_ff        <= nz_in;
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      left_ff      <= left_in;
      total_ff     <= total_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // Digit store with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= digit_mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ascii_char  = rsp_char_ff;
   assign rsp_last_char   = rsp_last_ff;
   assign rsp_char_count  = rsp_count_ff;
   assign rsp_radix_error = rsp_err_ff;

   // An error result is a single, final, empty character.
   a_err_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |->
         (rsp_last_ff && (rsp_count_ff == '0) && (rsp_char_ff == sita_pkg::ASCII_NUL)))
      else $error("radix error result malformed");

   // The divider only ever runs with a legal radix.
   a_div_base: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sita_pkg::BK_DIV) |->
         ((tag_ff.base >= sita_pkg::MIN_RADIX) && (tag_ff.base <= RW'(MAX_RADIX))))
      else $error("divider running with illegal radix");

   // While emitting, at least one digit remains and no more than the store holds.
   a_emit_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sita_pkg::BK_EMIT) |->
         ((left_ff != '0) && (left_ff <= CW'(VALUE_BITS))))
      else $error("digit count out of range while emitting");

   // Sending the final digit closes the transaction with a flagged result and its count.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && emit_last) |=>
         ((state_ff == sita_pkg::BK_IDLE) && rsp_valid_ff && rsp_last_ff &&
          (rsp_count_ff == sita_pkg::COUNT_W'(total_ff))))
      else $error("final digit did not close the string");

endmodule

// ----- src/signed_int_to_ascii_radix.sv -----
`timescale 1ns / 1ps
// Path: a request passes the front register and the queue, then the byte-wide divider works
// through the magnitude a byte at a time (CHUNKS = ceil(VALUE_BITS/8) bytes) for each digit.
// A minus sign goes out before the first digit. Throughput: one character per cycle while
// rsp_ready is high; the back end takes a new item only once all of the last one's characters are sent.
// Reset (synchronous, active high): radix returns to 10, queue and results empty, sequencer
// idle; the digit store is not cleared.

module signed_int_to_ascii_radix #(
   parameter int VALUE_BITS = sita_pkg::VALUE_BITS_DEF,
   parameter int MAX_RADIX  = sita_pkg::MAX_RADIX_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [sita_pkg::INPUT_W-1:0]   req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sita_pkg::CHAR_W-1:0]           rsp_ascii_char,
   output logic                                  rsp_last_char,
   output logic [sita_pkg::COUNT_W-1:0]          rsp_char_count,
   output logic                                  rsp_radix_error,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sita_pkg::RADIX_W-1:0]          csr_radix
);

   localparam int TAGW = $bits(sita_pkg::item_tag_type);
   localparam int QW   = TAGW + VALUE_BITS;

   logic [sita_pkg::RADIX_W-1:0]  radix_ff, radix_in;
   logic                          fr_valid, fr_ready;
   logic [VALUE_BITS-1:0]         fr_mag;
   sita_pkg::item_tag_type        fr_tag;
   logic                          q_valid, q_ready;
   logic [QW-1:0]                 q_data;
   logic [VALUE_BITS-1:0]         q_mag;
   sita_pkg::item_tag_type        q_tag;

   // Radix register; a write transaction always completes at once.
   assign csr_ready = 1'b1;
   assign radix_in  = (csr_valid && csr_ready) ? csr_radix : radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= sita_pkg::RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   // Front: accept and classify.
   sita_front #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_RADIX  (MAX_RADIX)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .radix     (radix_ff),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_mag   (fr_mag),
      .out_tag   (fr_tag)
   );

   // Queue between front and back.
   sita_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  ({fr_tag, fr_mag}),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   assign q_tag = sita_pkg::item_tag_type'(q_data[QW-1 -: TAGW]);
   assign q_mag = q_data[VALUE_BITS-1:0];

   // Back: digit extraction and character output.
   sita_back #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_RADIX  (MAX_RADIX)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (q_valid),
      .in_ready        (q_ready),
      .in_mag          (q_mag),
      .in_tag          (q_tag),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ascii_char  (rsp_ascii_char),
      .rsp_last_char   (rsp_last_char),
      .rsp_char_count  (rsp_char_count),
      .rsp_radix_error (rsp_radix_error)
   );

endmodule
